[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/tlpf_pkg.sv]
// ---------------------------------------------------------------------------
// tlpf_pkg
// Types and constants shared by the three-class priority FIFO.
// ---------------------------------------------------------------------------
package tlpf_pkg;

  localparam int CLASS_DEPTH = 1024;
  localparam int NUM_CLASSES = 3;
  localparam int ID_W        = 16;
  localparam int CAT_W       = 2;
  localparam int STAT_W      = 2;
  localparam int PTR_W       = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int FILL_W      = $clog2(CLASS_DEPTH + 1);
  localparam int NUM_ENTRIES = NUM_CLASSES * CLASS_DEPTH;
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);

  // action codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // class codes
  localparam logic [CAT_W-1:0] CAT_GENERAL = 2'd0;
  localparam logic [CAT_W-1:0] CAT_SENIOR  = 2'd1;
  localparam logic [CAT_W-1:0] CAT_VIP     = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STAT_W-1:0] ST_SERVED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic              action;
    logic [ID_W-1:0]   passenger_id;
    logic [CAT_W-1:0]  category;
  } tlpf_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   served_id;
    logic [CAT_W-1:0]  served_category;
  } tlpf_out_t;

  // decision of the pointer file for the transaction on the input
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CAT_W-1:0]  cls;
    logic [ADDR_W-1:0] addr;
  } tlpf_dec_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   wdata;
  } tlpf_ram_req_t;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } tlpf_state_t;

endpackage

[hdl/tlpf_id_ram.sv]
// ---------------------------------------------------------------------------
// tlpf_id_ram
// Single-port id store, one region per class, registered read data.
// ---------------------------------------------------------------------------
module tlpf_id_ram (
  input  logic                    clk,
  input  tlpf_pkg::tlpf_ram_req_t req,
  output logic [tlpf_pkg::ID_W-1:0] rdata
);
  import tlpf_pkg::*;

  logic [ID_W-1:0] mem [NUM_ENTRIES];
  logic [ID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // data holds until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/tlpf_ptr_file.sv]
// ---------------------------------------------------------------------------
// tlpf_ptr_file
// Per-class head, tail and fill count; picks the class and store address.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tlpf_ptr_file (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    upd,
  input  logic                    action,
  input  logic [tlpf_pkg::CAT_W-1:0] category,
  output tlpf_pkg::tlpf_dec_t     dec
);
  import tlpf_pkg::*;

  logic [NUM_CLASSES-1:0][PTR_W-1:0]  head_r, head_nxt;
  logic [NUM_CLASSES-1:0][PTR_W-1:0]  tail_r, tail_nxt;
  logic [NUM_CLASSES-1:0][FILL_W-1:0] fill_r, fill_nxt;

  logic [CAT_W-1:0] enq_cls;
  logic [CAT_W-1:0] deq_cls;
  logic             all_empty;
  logic             enq_full;
  logic [PTR_W-1:0] slot;
  logic [PTR_W-1:0] slot_inc;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
    logic [PTR_W:0] sum;
    sum = {1'b0, s} + 1'b1;
    return (sum == (PTR_W+1)'(CLASS_DEPTH)) ? '0 : sum[PTR_W-1:0];
  endfunction

  // unused class code is stored as general
  always_comb begin
    unique case (category)
      CAT_VIP:    enq_cls = CAT_VIP;
      CAT_SENIOR: enq_cls = CAT_SENIOR;
      default:    enq_cls = CAT_GENERAL;
    endcase
  end

  always_comb begin
    all_empty = 1'b0;
    if (fill_r[CAT_VIP] != '0) begin
      deq_cls = CAT_VIP;
    end else if (fill_r[CAT_SENIOR] != '0) begin
      deq_cls = CAT_SENIOR;
    end else begin
      deq_cls   = CAT_GENERAL;
      all_empty = (fill_r[CAT_GENERAL] == '0);
    end
  end

  assign enq_full = (fill_r[enq_cls] == FILL_W'(CLASS_DEPTH));

  always_comb begin
    if (action == ACT_ENQ) begin
      dec.cls    = enq_cls;
      dec.status = enq_full ? ST_FULL : ST_ENQUEUED;
      slot       = tail_r[enq_cls];
    end else begin
      dec.cls    = all_empty ? CAT_GENERAL : deq_cls;
      dec.status = all_empty ? ST_EMPTY : ST_SERVED;
      slot       = head_r[deq_cls];
    end
    dec.addr = ADDR_W'(ADDR_W'(dec.cls) * ADDR_W'(CLASS_DEPTH)) + ADDR_W'(slot);
  end

  assign slot_inc = next_slot(slot);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (upd) begin
      if (dec.status == ST_ENQUEUED) begin
        tail_nxt[dec.cls] = slot_inc;
        fill_nxt[dec.cls] = fill_r[dec.cls] + 1'b1;
      end else if (dec.status == ST_SERVED) begin
        head_nxt[dec.cls] = slot_inc;
        fill_nxt[dec.cls] = fill_r[dec.cls] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, (fill_r[0] <= FILL_W'(CLASS_DEPTH)) && (fill_r[1] <= FILL_W'(CLASS_DEPTH)) && (fill_r[2] <= FILL_W'(CLASS_DEPTH)), "class fill above depth")
  `ASSERT_NEXT(a_full_keeps, clk, rst_n, upd && (dec.status == ST_FULL), $stable(fill_r) && $stable(tail_r), "refused insert changed state")
  `ASSERT_IMPL(a_serve_nonempty, clk, rst_n, dec.status == ST_SERVED, fill_r[dec.cls] != '0, "serving an empty class")

endmodule

[hdl/three_level_priority_fifo_unit.sv]
// ---------------------------------------------------------------------------
// three_level_priority_fifo_unit
// Three-class priority queue, first-in-first-out within each class.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel carrying an enqueue (id, class) or a dequeue.
//   out_* : valid/ready channel, exactly one result per input transaction:
//           enqueued, served (id and class), empty, or class full.
//   The accept cycle of a transaction decides against the per-class
//   pointers and issues at most one id store access; in the busy state the
//   registered read data is then collected into the output register once it
//   is free. No new transaction is taken until the previous one is loaded.
//   in_ready is low while a transaction is pending; the next one is accepted
//   even while the previous result still sits in the output register.
//   When the receiver stalls, the pending result waits, and input is held
//   off until the output register frees.
//   Reset clears all pointers and fill counts, so every class starts empty;
//   the id store itself is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module three_level_priority_fifo_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tlpf_pkg::tlpf_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tlpf_pkg::tlpf_out_t  out_data
);
  import tlpf_pkg::*;

  tlpf_state_t       state_r, state_nxt;
  tlpf_dec_t         dec;
  tlpf_ram_req_t     ram_req;
  logic [ID_W-1:0]   ram_rdata;
  logic              accept;
  logic              out_free;
  logic              load;

  logic [STAT_W-1:0] pend_status_r;
  logic [CAT_W-1:0]  pend_cat_r;
  logic              out_valid_r, out_valid_nxt;
  tlpf_out_t         out_data_r;

  tlpf_ptr_file u_ptr_file (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (accept),
    .action   (in_data.action),
    .category (in_data.category),
    .dec      (dec)
  );

  tlpf_id_ram u_id_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_BUSY;
      S_BUSY: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_BUSY:  load     = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    ram_req.we    = accept && (dec.status == ST_ENQUEUED);
    ram_req.re    = accept && (dec.status == ST_SERVED);
    ram_req.addr  = dec.addr;
    ram_req.wdata = in_data.passenger_id;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status_r <= dec.status;
      pend_cat_r    <= (dec.status == ST_SERVED) ? dec.cls : CAT_GENERAL;
    end
    if (load) begin
      out_data_r.status          <= pend_status_r;
      out_data_r.served_id       <= (pend_status_r == ST_SERVED) ? ram_rdata : '0;
      out_data_r.served_category <= pend_cat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_r == S_BUSY, "accepted transaction not pending")
  `ASSERT_IMPL(a_ram_one_port, clk, rst_n, ram_req.we, !ram_req.re, "store read and write together")
  `ASSERT_IMPL(a_idle_fields, clk, rst_n, out_valid_r && (out_data_r.status != ST_SERVED), (out_data_r.served_id == '0) && (out_data_r.served_category == CAT_GENERAL), "fields set on non-serve result")

endmodule
